/* hw/rtl/bld_pkg.sv */
// bld_pkg: shared types, constants and the micro-program of the distortion map
// depends on nothing; used by bld_alu, bld_div and brown_lens_distortion_map
`timescale 1ns / 1ps
`default_nettype none

package bld_pkg;

   localparam int FRACTION_BITS  = 24;
   localparam int MAX_ITERATIONS = 10;
   localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
   localparam int PC_W           = 7;
   localparam int SRC_W          = 6;
   localparam int REG_W          = 5;
   localparam int DIV_W          = 32 + FRACTION_BITS;

   localparam logic [31:0] FX_ONE  = 32'(64'd1 << FRACTION_BITS);
   localparam logic [65:0] FX_HALF = 66'(64'd1 << (FRACTION_BITS - 1));
   localparam int          PREC_I  = ((2 ** FRACTION_BITS) + 50000) / 100000;
   localparam logic [32:0] PREC    = 33'(PREC_I);
   localparam logic [63:0] PREC_SQ = 64'(PREC_I) * 64'(PREC_I);
   localparam logic [63:0] EPS_SQ  = (2 * FRACTION_BITS >= 46)
                                     ? (64'd1 << ((2 * FRACTION_BITS - 46) & 63)) : 64'd0;

   localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
   localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

   typedef enum logic [3:0] {
      OP_MUL, OP_ADD, OP_SUB, OP_SC2, OP_SC4, OP_SC6, OP_NRM, OP_ABSLE,
      OP_DIV, OP_OUT, OP_BRA, OP_BRF, OP_BRNF, OP_JMP, OP_ITER, OP_CLRN
   } uop_op_type;

   typedef enum logic [1:0] {THR_LD, THR_LU, THR_EPS, THR_PREC} thr_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_IN_RADIUS   = 3'd1,
      ST_OUT_RADIUS  = 3'd2,
      ST_SINGULAR    = 3'd3,
      ST_NO_CONV     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      SQ_IDLE, SQ_FETCH, SQ_EXEC, SQ_EXEC2, SQ_WAIT, SQ_DIVW, SQ_RESP
   } seq_state_type;

   typedef enum logic [2:0] {
      CSR_K1, CSR_K2, CSR_K3, CSR_P1, CSR_P2, CSR_LIM_D, CSR_LIM_U
   } csr_index_type;

   typedef struct packed {
      uop_op_type        op;
      logic [REG_W-1:0]  dst;
      logic [SRC_W-1:0]  sa;
      logic [SRC_W-1:0]  sb;
      logic [PC_W-1:0]   tgt;
      thr_type           thr;
      status_type        st;
   } uop_type;

   typedef struct packed {
      logic       go;
      logic       second;
      uop_op_type op;
   } alu_ctl_type;

   // operand sources: scratch registers below 32, fixed sources at 32 and above
   localparam logic [SRC_W-1:0] R_X = 6'd0, R_Y = 6'd1, R_X2 = 6'd2, R_Y2 = 6'd3,
      R_XY = 6'd4, R_R2 = 6'd5, R_R4 = 6'd6, R_R6 = 6'd7, R_S = 6'd8, R_T = 6'd9,
      R_T2 = 6'd10, R_TX = 6'd11, R_TY = 6'd12, R_U = 6'd13, R_V = 6'd14,
      R_FX = 6'd15, R_FY = 6'd16, R_T3 = 6'd17, R_J00 = 6'd18, R_J01 = 6'd19,
      R_J11 = 6'd20, R_DET = 6'd21, R_NX = 6'd22, R_NY = 6'd23, R_DX = 6'd24,
      R_DY = 6'd25, R_PX = 6'd26, R_PY = 6'd27, R_P2X = 6'd28, R_P1Y = 6'd29;
   localparam logic [SRC_W-1:0] S_K1 = 6'd32, S_K2 = 6'd33, S_K3 = 6'd34,
      S_P1 = 6'd35, S_P2 = 6'd36, S_ONE = 6'd37, S_TU = 6'd38, S_TV = 6'd39,
      S_ZERO = 6'd40;

   localparam logic [PC_W-1:0] PC_DIST = 7'd8, PC_NEWT = 7'd40, PC_CONV = 7'd94,
      PC_FAIL1 = 7'd97, PC_FAIL2 = 7'd98, PC_FAIL3 = 7'd99, PC_FAIL4 = 7'd100;

   function automatic logic [31:0] sat32(input logic signed [65:0] v);
      if (v > S32_MAX) return 32'h7FFF_FFFF;
      else if (v < S32_MIN) return 32'h8000_0000;
      else return v[31:0];
   endfunction

   function automatic uop_type mk(input uop_op_type op, input logic [SRC_W-1:0] d,
                                  input logic [SRC_W-1:0] a, input logic [SRC_W-1:0] b,
                                  input logic [PC_W-1:0] t, input thr_type th,
                                  input status_type st);
      uop_type u;
      u.op  = op;
      u.dst = d[REG_W-1:0];
      u.sa  = a;
      u.sb  = b;
      u.tgt = t;
      u.thr = th;
      u.st  = st;
      return u;
   endfunction

   function automatic uop_type op3(input uop_op_type op, input logic [SRC_W-1:0] d,
                                   input logic [SRC_W-1:0] a, input logic [SRC_W-1:0] b);
      return mk(op, d, a, b, '0, THR_LD, ST_OK);
   endfunction

   function automatic uop_type br(input uop_op_type op, input logic [PC_W-1:0] t);
      return mk(op, R_X, S_ZERO, S_ZERO, t, THR_LD, ST_OK);
   endfunction

   function automatic uop_type nrm(input logic [SRC_W-1:0] a, input logic [SRC_W-1:0] b,
                                   input thr_type th);
      return mk(OP_NRM, R_X, a, b, '0, th, ST_OK);
   endfunction

   function automatic uop_type outp(input logic [SRC_W-1:0] a, input logic [SRC_W-1:0] b,
                                    input status_type st);
      return mk(OP_OUT, R_X, a, b, '0, THR_LD, st);
   endfunction

   // micro-program: radius checks, distortion, newton loop for the inverse
   function automatic uop_type uop_at(input logic [PC_W-1:0] pc);
      uop_type u;
      unique case (pc)
         7'd0:   u = br(OP_BRA, 7'd3);
         7'd1:   u = nrm(S_TU, S_TV, THR_LU);
         7'd2:   u = br(OP_JMP, 7'd4);
         7'd3:   u = nrm(S_TU, S_TV, THR_LD);
         7'd4:   u = br(OP_BRF, PC_FAIL1);
         7'd5:   u = op3(OP_ADD, R_X, S_TU, S_ZERO);
         7'd6:   u = op3(OP_ADD, R_Y, S_TV, S_ZERO);
         7'd7:   u = br(OP_CLRN, 7'd0);
         7'd8:   u = op3(OP_MUL, R_X2, R_X, R_X);
         7'd9:   u = op3(OP_MUL, R_Y2, R_Y, R_Y);
         7'd10:  u = op3(OP_MUL, R_XY, R_X, R_Y);
         7'd11:  u = op3(OP_ADD, R_R2, R_X2, R_Y2);
         7'd12:  u = op3(OP_MUL, R_R4, R_R2, R_R2);
         7'd13:  u = op3(OP_MUL, R_R6, R_R4, R_R2);
         7'd14:  u = op3(OP_MUL, R_T, S_K1, R_R2);
         7'd15:  u = op3(OP_ADD, R_S, S_ONE, R_T);
         7'd16:  u = op3(OP_MUL, R_T, S_K2, R_R4);
         7'd17:  u = op3(OP_ADD, R_S, R_S, R_T);
         7'd18:  u = op3(OP_MUL, R_T, S_K3, R_R6);
         7'd19:  u = op3(OP_ADD, R_S, R_S, R_T);
         7'd20:  u = op3(OP_MUL, R_T, S_P1, R_XY);
         7'd21:  u = op3(OP_SC2, R_T, R_T, S_ZERO);
         7'd22:  u = op3(OP_SC2, R_T2, R_X2, S_ZERO);
         7'd23:  u = op3(OP_ADD, R_T2, R_R2, R_T2);
         7'd24:  u = op3(OP_MUL, R_T2, S_P2, R_T2);
         7'd25:  u = op3(OP_ADD, R_TX, R_T, R_T2);
         7'd26:  u = op3(OP_MUL, R_T, S_P2, R_XY);
         7'd27:  u = op3(OP_SC2, R_T, R_T, S_ZERO);
         7'd28:  u = op3(OP_SC2, R_T2, R_Y2, S_ZERO);
         7'd29:  u = op3(OP_ADD, R_T2, R_R2, R_T2);
         7'd30:  u = op3(OP_MUL, R_T2, S_P1, R_T2);
         7'd31:  u = op3(OP_ADD, R_TY, R_T, R_T2);
         7'd32:  u = op3(OP_MUL, R_T, R_S, R_X);
         7'd33:  u = op3(OP_ADD, R_U, R_T, R_TX);
         7'd34:  u = op3(OP_MUL, R_T, R_S, R_Y);
         7'd35:  u = op3(OP_ADD, R_V, R_T, R_TY);
         7'd36:  u = br(OP_BRA, PC_NEWT);
         7'd37:  u = nrm(R_U, R_V, THR_LD);
         7'd38:  u = br(OP_BRF, PC_FAIL2);
         7'd39:  u = outp(R_U, R_V, ST_OK);
         7'd40:  u = op3(OP_SUB, R_FX, R_U, S_TU);
         7'd41:  u = op3(OP_SUB, R_FY, R_V, S_TV);
         7'd42:  u = nrm(R_FX, R_FY, THR_EPS);
         7'd43:  u = br(OP_BRNF, PC_CONV);
         7'd44:  u = op3(OP_MUL, R_T, S_K3, R_R4);
         7'd45:  u = op3(OP_SC6, R_T, R_T, S_ZERO);
         7'd46:  u = op3(OP_MUL, R_T2, S_K2, R_R2);
         7'd47:  u = op3(OP_SC4, R_T2, R_T2, S_ZERO);
         7'd48:  u = op3(OP_ADD, R_T, R_T, R_T2);
         7'd49:  u = op3(OP_SC2, R_T2, S_K1, S_ZERO);
         7'd50:  u = op3(OP_ADD, R_T3, R_T, R_T2);
         7'd51:  u = op3(OP_MUL, R_P2X, S_P2, R_X);
         7'd52:  u = op3(OP_MUL, R_P1Y, S_P1, R_Y);
         7'd53:  u = op3(OP_SC6, R_T, R_P2X, S_ZERO);
         7'd54:  u = op3(OP_ADD, R_T, R_S, R_T);
         7'd55:  u = op3(OP_SC2, R_T2, R_P1Y, S_ZERO);
         7'd56:  u = op3(OP_ADD, R_T, R_T, R_T2);
         7'd57:  u = op3(OP_MUL, R_T2, R_T3, R_X2);
         7'd58:  u = op3(OP_ADD, R_J00, R_T, R_T2);
         7'd59:  u = op3(OP_SC2, R_T, R_P2X, S_ZERO);
         7'd60:  u = op3(OP_ADD, R_T, R_S, R_T);
         7'd61:  u = op3(OP_SC6, R_T2, R_P1Y, S_ZERO);
         7'd62:  u = op3(OP_ADD, R_T, R_T, R_T2);
         7'd63:  u = op3(OP_MUL, R_T2, R_T3, R_Y2);
         7'd64:  u = op3(OP_ADD, R_J11, R_T, R_T2);
         7'd65:  u = op3(OP_MUL, R_T, S_P1, R_X);
         7'd66:  u = op3(OP_MUL, R_T2, S_P2, R_Y);
         7'd67:  u = op3(OP_ADD, R_T, R_T, R_T2);
         7'd68:  u = op3(OP_SC2, R_T, R_T, S_ZERO);
         7'd69:  u = op3(OP_MUL, R_T2, R_T3, R_XY);
         7'd70:  u = op3(OP_ADD, R_J01, R_T, R_T2);
         7'd71:  u = op3(OP_MUL, R_T, R_J00, R_J11);
         7'd72:  u = op3(OP_MUL, R_T2, R_J01, R_J01);
         7'd73:  u = op3(OP_SUB, R_DET, R_T, R_T2);
         7'd74:  u = op3(OP_ABSLE, R_X, R_DET, S_ZERO);
         7'd75:  u = br(OP_BRF, PC_FAIL3);
         7'd76:  u = op3(OP_MUL, R_T, R_J11, R_FX);
         7'd77:  u = op3(OP_MUL, R_T2, R_J01, R_FY);
         7'd78:  u = op3(OP_SUB, R_NX, R_T, R_T2);
         7'd79:  u = op3(OP_MUL, R_T, R_J00, R_FY);
         7'd80:  u = op3(OP_MUL, R_T2, R_J01, R_FX);
         7'd81:  u = op3(OP_SUB, R_NY, R_T, R_T2);
         7'd82:  u = op3(OP_DIV, R_DX, R_NX, R_DET);
         7'd83:  u = op3(OP_DIV, R_DY, R_NY, R_DET);
         7'd84:  u = op3(OP_ADD, R_PX, R_X, S_ZERO);
         7'd85:  u = op3(OP_ADD, R_PY, R_Y, S_ZERO);
         7'd86:  u = op3(OP_SUB, R_X, R_X, R_DX);
         7'd87:  u = op3(OP_SUB, R_Y, R_Y, R_DY);
         7'd88:  u = br(OP_ITER, 7'd0);
         7'd89:  u = br(OP_BRF, PC_FAIL4);
         7'd90:  u = op3(OP_SUB, R_T, R_X, R_PX);
         7'd91:  u = op3(OP_SUB, R_T2, R_Y, R_PY);
         7'd92:  u = nrm(R_T, R_T2, THR_PREC);
         7'd93:  u = br(OP_BRF, PC_DIST);
         7'd94:  u = nrm(R_X, R_Y, THR_LU);
         7'd95:  u = br(OP_BRF, PC_FAIL2);
         7'd96:  u = outp(R_X, R_Y, ST_OK);
         7'd97:  u = outp(S_ZERO, S_ZERO, ST_IN_RADIUS);
         7'd98:  u = outp(S_ZERO, S_ZERO, ST_OUT_RADIUS);
         7'd99:  u = outp(S_ZERO, S_ZERO, ST_SINGULAR);
         7'd100: u = outp(S_ZERO, S_ZERO, ST_NO_CONV);
         default: u = br(OP_JMP, 7'd0);
      endcase
      return u;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/bld_chan_if.sv */
// bld_req_if, bld_rsp_if: valid/ready channels for point words and result words
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface bld_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic signed [31:0] in_x;
   logic signed [31:0] in_y;
   modport source (output valid, action, in_x, in_y, input ready);
   modport sink   (input valid, action, in_x, in_y, output ready);
endinterface

interface bld_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic [2:0]         status;
   modport source (output valid, out_x, out_y, status, input ready);
   modport sink   (input valid, out_x, out_y, status, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bld_alu.sv */
// bld_alu: shared two-stage unit (33x33 multiply, saturating add, compares)
// depends on bld_pkg
`timescale 1ns / 1ps
`default_nettype none

module bld_alu (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bld_pkg::alu_ctl_type ctl,
   input  wire logic signed [31:0]  a,
   input  wire logic signed [31:0]  b,
   input  wire logic [63:0]         thr,
   output logic                     done,
   output logic [31:0]              res,
   output logic                     flag
);
   import bld_pkg::*;

   logic signed [32:0] m1, m2, mag_src;
   logic signed [34:0] ea, eb, sum;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [34:0] sum_ff;
   logic signed [32:0] abs_ff, abs_in;
   uop_op_type         op_ff;
   logic               sec_ff, v1_ff;
   logic [63:0]        acc_ff, acc_in;
   logic [31:0]        res_ff, res_in;
   logic               flag_ff, flag_in, done_ff, done_in;
   logic signed [65:0] rnd;

   always_comb begin
      mag_src = ctl.second ? 33'(b) : 33'(a);
      if (mag_src < 0) mag_src = -mag_src;
      if (ctl.op == OP_NRM) begin
         m1 = mag_src;
         m2 = mag_src;
      end else begin
         m1 = 33'(a);
         m2 = 33'(b);
      end
      prod_in = 66'(m1) * 66'(m2);
      ea = 35'(a);
      eb = 35'(b);
      unique case (ctl.op)
         OP_SUB:  sum = ea - eb;
         OP_SC2:  sum = ea <<< 1;
         OP_SC4:  sum = ea <<< 2;
         OP_SC6:  sum = (ea <<< 2) + (ea <<< 1);
         default: sum = ea + eb;
      endcase
      abs_in = (a < 0) ? -33'(a) : 33'(a);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.go;
      end
      if (ctl.go) begin
         prod_ff <= prod_in;
         sum_ff  <= sum;
         abs_ff  <= abs_in;
         op_ff   <= ctl.op;
         sec_ff  <= ctl.second;
      end
   end

   // second stage: rounding, saturation and the flag compares
   always_comb begin
      rnd     = prod_ff + $signed(FX_HALF);
      res_in  = res_ff;
      flag_in = flag_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (v1_ff) begin
         unique case (op_ff)
            OP_MUL: begin
               res_in  = sat32(rnd >>> FRACTION_BITS);
               done_in = 1'b1;
            end
            OP_NRM: begin
               if (!sec_ff) begin
                  acc_in = prod_ff[63:0];
               end else begin
                  flag_in = (acc_ff + prod_ff[63:0]) > thr;
                  done_in = 1'b1;
               end
            end
            OP_ABSLE: begin
               flag_in = $unsigned(abs_ff) <= PREC;
               done_in = 1'b1;
            end
            default: begin
               res_in  = sat32(66'(sum_ff));
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      res_ff  <= res_in;
      flag_ff <= flag_in;
      acc_ff  <= acc_in;
   end

   assign done = done_ff;
   assign res  = res_ff;
   assign flag = flag_ff;

endmodule

`default_nettype wire

/* hw/rtl/bld_div.sv */
// bld_div: restoring divider, (num * 2^F) / den truncated toward zero, saturated
// depends on bld_pkg; one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module bld_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] num,
   input  wire logic signed [31:0] den,
   output logic                    done,
   output logic [31:0]             quo
);
   import bld_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] dvd_ff;
   logic [31:0]      rem_ff, dmag_ff, nmag, dmag, rem_next;
   logic             neg_ff, busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [32:0]      sh;
   logic [33:0]      diff;
   logic             qb;

   assign nmag = num[31] ? (~num + 32'd1) : num;
   assign dmag = den[31] ? (~den + 32'd1) : den;

   always_comb begin
      sh       = {rem_ff, dvd_ff[DIV_W-1]};
      diff     = {1'b0, sh} - {2'b00, dmag_ff};
      qb       = !diff[33];
      rem_next = qb ? diff[31:0] : sh[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         dvd_ff  <= {nmag, {FRACTION_BITS{1'b0}}};
         rem_ff  <= '0;
         dmag_ff <= dmag;
         neg_ff  <= num[31] ^ den[31];
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DIV_W-2:0], qb};
         rem_ff <= rem_next;
      end
   end

   always_comb begin
      if (neg_ff) begin
         quo = (dvd_ff > DIV_W'(64'h8000_0000)) ? 32'h8000_0000
                                                : (~dvd_ff[31:0] + 32'd1);
      end else begin
         quo = (dvd_ff > DIV_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : dvd_ff[31:0];
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

/* hw/rtl/brown_lens_distortion_map.sv */
// brown_lens_distortion_map: brown radial/tangential distortion and its newton inverse
// throughput: one word at a time, set by the micro-op sequencer and the shared unit
// reset: synchronous, coefficients 0 and radius limits all ones; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module brown_lens_distortion_map (
   input  wire logic  clock,
   input  wire logic  reset,
   bld_req_if.sink    req_chan,
   bld_rsp_if.source  rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import bld_pkg::*;

   // configuration registers
   logic signed [31:0] k1_ff, k2_ff, k3_ff, p1_ff, p2_ff;
   logic [30:0]        lim_d_ff, lim_u_ff;

   // sequencer state
   seq_state_type      state_ff, state_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic               flag_ff, flag_in;
   logic               act_ff, act_in;
   logic signed [31:0] tu_ff, tu_in, tv_ff, tv_in;
   logic [31:0]        ox_ff, ox_in, oy_ff, oy_in;
   status_type         st_ff, st_in;
   uop_type            uop;

   // scratch register file, two registered reads and one write
   logic [31:0]        mem [32];
   logic [31:0]        rda_ff, rdb_ff;
   logic               mem_we;
   logic [31:0]        mem_wd;

   logic signed [31:0] opa, opb;
   logic [63:0]        thr;
   alu_ctl_type        alu_ctl;
   logic               alu_done, alu_flag;
   logic [31:0]        alu_res;
   logic               div_start, div_done;
   logic [31:0]        div_quo;

   assign uop = uop_at(pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff    <= '0;
         k2_ff    <= '0;
         k3_ff    <= '0;
         p1_ff    <= '0;
         p2_ff    <= '0;
         lim_d_ff <= '1;
         lim_u_ff <= '1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_K1:    k1_ff    <= csr_data;
            CSR_K2:    k2_ff    <= csr_data;
            CSR_K3:    k3_ff    <= csr_data;
            CSR_P1:    p1_ff    <= csr_data;
            CSR_P2:    p2_ff    <= csr_data;
            CSR_LIM_D: lim_d_ff <= csr_data[30:0];
            CSR_LIM_U: lim_u_ff <= csr_data[30:0];
            default: ;  // index past the list: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rda_ff <= mem[uop.sa[REG_W-1:0]];
      rdb_ff <= mem[uop.sb[REG_W-1:0]];
      if (mem_we) begin
         mem[uop.dst] <= mem_wd;
      end
   end

   // operand selection: scratch registers or fixed sources
   always_comb begin
      if (!uop.sa[SRC_W-1]) begin
         opa = rda_ff;
      end else begin
         unique case (uop.sa)
            S_K1:    opa = k1_ff;
            S_K2:    opa = k2_ff;
            S_K3:    opa = k3_ff;
            S_P1:    opa = p1_ff;
            S_P2:    opa = p2_ff;
            S_ONE:   opa = FX_ONE;
            S_TU:    opa = tu_ff;
            S_TV:    opa = tv_ff;
            default: opa = '0;
         endcase
      end
      if (!uop.sb[SRC_W-1]) begin
         opb = rdb_ff;
      end else begin
         unique case (uop.sb)
            S_K1:    opb = k1_ff;
            S_K2:    opb = k2_ff;
            S_K3:    opb = k3_ff;
            S_P1:    opb = p1_ff;
            S_P2:    opb = p2_ff;
            S_ONE:   opb = FX_ONE;
            S_TU:    opb = tu_ff;
            S_TV:    opb = tv_ff;
            default: opb = '0;
         endcase
      end
      // squared radius limits live on the 2F grid
      unique case (uop.thr)
         THR_LD:   thr = 64'(lim_d_ff) << FRACTION_BITS;
         THR_LU:   thr = 64'(lim_u_ff) << FRACTION_BITS;
         THR_EPS:  thr = EPS_SQ;
         THR_PREC: thr = PREC_SQ;
      endcase
   end

   bld_alu u_alu (
      .clock (clock),
      .reset (reset),
      .ctl   (alu_ctl),
      .a     (opa),
      .b     (opb),
      .thr   (thr),
      .done  (alu_done),
      .res   (alu_res),
      .flag  (alu_flag)
   );

   bld_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (opa),
      .den   (opb),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         pc_ff    <= '0;
         iter_ff  <= '0;
         flag_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         iter_ff  <= iter_in;
         flag_ff  <= flag_in;
      end
      act_ff <= act_in;
      tu_ff  <= tu_in;
      tv_ff  <= tv_in;
      ox_ff  <= ox_in;
      oy_ff  <= oy_in;
      st_ff  <= st_in;
   end

   // sequencer: fetch a micro-op, branch in place, run it on the shared unit or the divider, or emit the result
   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      iter_in   = iter_ff;
      flag_in   = flag_ff;
      act_in    = act_ff;
      tu_in     = tu_ff;
      tv_in     = tv_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      st_in     = st_ff;
      alu_ctl   = '{go: 1'b0, second: 1'b0, op: uop.op};
      div_start = 1'b0;
      mem_we    = 1'b0;
      mem_wd    = alu_res;
      unique case (state_ff)
         SQ_IDLE: begin
            if (req_chan.valid) begin
               act_in   = req_chan.action;
               tu_in    = req_chan.in_x;
               tv_in    = req_chan.in_y;
               pc_in    = '0;
               state_in = SQ_FETCH;
            end
         end
         SQ_FETCH: begin
            unique case (uop.op)
               OP_BRA:  pc_in = act_ff ? uop.tgt : pc_ff + 1'b1;
               OP_BRF:  pc_in = flag_ff ? uop.tgt : pc_ff + 1'b1;
               OP_BRNF: pc_in = flag_ff ? pc_ff + 1'b1 : uop.tgt;
               OP_JMP:  pc_in = uop.tgt;
               OP_ITER: begin
                  iter_in = iter_ff + 1'b1;
                  flag_in = (iter_ff + 1'b1) >= ITER_W'(MAX_ITERATIONS);
                  pc_in   = pc_ff + 1'b1;
               end
               OP_CLRN: begin
                  iter_in = '0;
                  pc_in   = pc_ff + 1'b1;
               end
               default: state_in = SQ_EXEC;
            endcase
         end
         SQ_EXEC: begin
            unique case (uop.op)
               OP_NRM: begin
                  alu_ctl.go = 1'b1;
                  state_in   = SQ_EXEC2;
               end
               OP_DIV: begin
                  div_start = 1'b1;
                  state_in  = SQ_DIVW;
               end
               OP_OUT: begin
                  ox_in    = (uop.st == ST_OK) ? opa : '0;
                  oy_in    = (uop.st == ST_OK) ? opb : '0;
                  st_in    = uop.st;
                  state_in = SQ_RESP;
               end
               default: begin
                  alu_ctl.go = 1'b1;
                  state_in   = SQ_WAIT;
               end
            endcase
         end
         SQ_EXEC2: begin
            alu_ctl.go     = 1'b1;
            alu_ctl.second = 1'b1;
            state_in       = SQ_WAIT;
         end
         SQ_WAIT: begin
            if (alu_done) begin
               if (uop.op == OP_NRM || uop.op == OP_ABSLE) begin
                  flag_in = alu_flag;
               end else begin
                  mem_we = 1'b1;
               end
               pc_in    = pc_ff + 1'b1;
               state_in = SQ_FETCH;
            end
         end
         SQ_DIVW: begin
            mem_wd = div_quo;
            if (div_done) begin
               mem_we   = 1'b1;
               pc_in    = pc_ff + 1'b1;
               state_in = SQ_FETCH;
            end
         end
         SQ_RESP: begin
            if (rsp_chan.ready) begin
               state_in = SQ_IDLE;
            end
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   assign req_chan.ready  = (state_ff == SQ_IDLE);
   assign rsp_chan.valid  = (state_ff == SQ_RESP);
   assign rsp_chan.out_x  = ox_ff;
   assign rsp_chan.out_y  = oy_ff;
   assign rsp_chan.status = st_ff;

   // a result word and a new point word never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request taken while a result word waits");

   // failed mappings carry a zero point
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != ST_OK) |-> (rsp_chan.out_x == 0 &&
                                                        rsp_chan.out_y == 0))
      else $error("non-zero point on a failed result word");

   // newton step count stays within bounds
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      iter_ff <= ITER_W'(MAX_ITERATIONS))
      else $error("newton step count overran");

   // the shared unit only finishes while the sequencer waits for it
   a_alu_done: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> state_ff == SQ_WAIT)
      else $error("shared unit result arrived outside the wait state");

endmodule

`default_nettype wire
